// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the formatter RTL.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define FDDF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the trigger holds, the consequence holds in the next cycle.
`define FDDF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fddf_pkg.sv -----
package fddf_pkg;

  // Symbol codes held for each display position.
  localparam logic [4:0] SYM_BLANK = 5'd16;
  localparam logic [4:0] SYM_DASH  = 5'd17;
  localparam logic [4:0] SYM_E     = 5'd18;
  localparam logic [4:0] SYM_R     = 5'd19;

  // Command codes on the func field.
  localparam logic [1:0] FUNC_DEC   = 2'd0;
  localparam logic [1:0] FUNC_HEX   = 2'd1;
  localparam logic [1:0] FUNC_ERR   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Decimal range limits.
  localparam logic signed [31:0] DEC_MAX = 32'sd9999;
  localparam logic signed [31:0] DEC_MIN = -32'sd999;

  // Fixed-point reciprocals for division by 10, 100 and 1000 on values up to 9999.
  localparam logic [12:0] RECIP_10   = 13'd6554;  // shift by 16
  localparam logic [12:0] RECIP_100  = 13'd5243;  // shift by 19
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // shift by 23

  // Classified command kinds passed from the front to the back.
  typedef enum logic [2:0] {
    KIND_DEC,
    KIND_DEC_OOR,
    KIND_HEX,
    KIND_ERR,
    KIND_CLEAR
  } kind_e;

  // Input transaction.
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] number;
  } fddf_in_t;

  // Result transaction.
  typedef struct packed {
    logic [4:0] sym_pos0;
    logic [4:0] sym_pos1;
    logic [4:0] sym_pos2;
    logic [4:0] sym_pos3;
    logic       ignored;
  } fddf_out_t;

  // Classified command with the decimal quotients already formed.
  typedef struct packed {
    kind_e       kind;
    logic        neg;
    logic [13:0] mag;
    logic [9:0]  quo10;
    logic [6:0]  quo100;
    logic [3:0]  quo1000;
    logic [15:0] hex;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

// ----- sv/fddf_front.sv -----
`include "assert_macros.svh"

module fddf_front import fddf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  fddf_in_t  in_data_i,
  output logic      full,
  input  logic      cmd_pop_i,
  output cmd_head_t cmd_head_o
);

  cmd_t        cls;
  logic [13:0] mag_abs;
  logic [26:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;

  cmd_t        ent_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push_fire;
  logic        pop_fire;

  // Magnitude of an in-range decimal value and its quotients by powers of ten.
  always_comb begin
    mag_abs  = in_data_i.number[31] ? 14'(~in_data_i.number[13:0] + 14'd1)
                                    : in_data_i.number[13:0];
    prod10   = 27'(mag_abs) * 27'(RECIP_10);
    prod100  = 27'(mag_abs) * 27'(RECIP_100);
    prod1000 = 28'(mag_abs) * 28'(RECIP_1000);
  end

  // Classify the incoming command.
  always_comb begin
    cls         = '0;
    cls.neg     = in_data_i.number[31];
    cls.mag     = mag_abs;
    cls.quo10   = prod10[25:16];
    cls.quo100  = prod100[25:19];
    cls.quo1000 = prod1000[26:23];
    cls.hex     = in_data_i.number[15:0];
    case (in_data_i.func)
      FUNC_DEC: begin
        if (in_data_i.number > DEC_MAX || in_data_i.number < DEC_MIN) begin
          cls.kind = KIND_DEC_OOR;
        end else begin
          cls.kind = KIND_DEC;
        end
      end
      FUNC_HEX: begin
        if (in_data_i.number[31] || (|in_data_i.number[30:16])) begin
          cls.kind = KIND_ERR;
        end else begin
          cls.kind = KIND_HEX;
        end
      end
      FUNC_ERR: cls.kind = KIND_ERR;
      default:  cls.kind = KIND_CLEAR;
    endcase
  end

  // Two-entry command queue toward the back end.
  assign full       = (cnt_q == 2'd2);
  assign push_fire  = push && !full;
  assign pop_fire   = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_head_o = '{valid: (cnt_q != 2'd0), cmd: ent_q[rd_q]};

  always_comb begin
    wr_d  = push_fire ? ~wr_q : wr_q;
    rd_d  = pop_fire ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_fire) - 2'(pop_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      ent_q[wr_q] <= cls;
    end
  end

  `FDDF_ASSERT_ALWAYS(a_cmd_cnt_bound, cnt_q <= 2'd2, "command queue count overflow")
  `FDDF_ASSERT_NEXT(a_cmd_push_lands, push_fire && !pop_fire, cnt_q != 2'd0,
    "accepted command not held in queue")

endmodule

// ----- sv/fddf_back.sv -----
`include "assert_macros.svh"

module fddf_back import fddf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_head_t cmd_head_i,
  output logic      cmd_pop_o,
  output fddf_out_t out_data_o,
  output logic      empty,
  input  logic      pop
);

  logic [3:0][4:0] sym_q, sym_d;
  cmd_t            cmd;
  logic [13:0]     dig0_w;
  logic [9:0]      dig1_w;
  logic [6:0]      dig2_w;
  logic [3:0]      quo [4];
  logic            is_zero [4];
  logic            ignored;
  logic            cmd_fire;

  fddf_out_t       res_q [2];
  logic            rwr_q, rwr_d;
  logic            rrd_q, rrd_d;
  logic [1:0]      rcnt_q, rcnt_d;
  logic            res_pop;

  assign cmd = cmd_head_i.cmd;

  // Decimal digits from the quotients formed in the front end.
  always_comb begin
    dig0_w = cmd.mag - {cmd.quo10, 3'b000} - {3'b000, cmd.quo10, 1'b0};
    dig1_w = cmd.quo10 - {cmd.quo100, 3'b000} - {2'b00, cmd.quo100, 1'b0};
    dig2_w = cmd.quo100 - {cmd.quo1000[3:0], 3'b000} - {2'b00, cmd.quo1000, 1'b0};
    quo[0] = dig0_w[3:0];
    quo[1] = dig1_w[3:0];
    quo[2] = dig2_w[3:0];
    quo[3] = cmd.quo1000;
    is_zero[0] = (cmd.mag == 14'd0);
    is_zero[1] = (cmd.quo10 == 10'd0);
    is_zero[2] = (cmd.quo100 == 7'd0);
    is_zero[3] = (cmd.quo1000 == 4'd0);
  end

  // Next held symbols for the command at the queue head.
  always_comb begin
    sym_d   = sym_q;
    ignored = 1'b0;
    case (cmd.kind)
      KIND_DEC: begin
        sym_d[0] = {1'b0, quo[0]};
        for (int i = 1; i < 4; i++) begin
          if (!is_zero[i]) begin
            sym_d[i] = {1'b0, quo[i]};
          end else if (cmd.neg && (i == 1 || !is_zero[i-1])) begin
            sym_d[i] = SYM_DASH;
          end else begin
            sym_d[i] = SYM_BLANK;
          end
        end
      end
      KIND_DEC_OOR: ignored = 1'b1;
      KIND_HEX: begin
        for (int i = 0; i < 4; i++) begin
          sym_d[i] = {1'b0, cmd.hex[4*i +: 4]};
        end
      end
      KIND_ERR: sym_d = {SYM_E, SYM_R, SYM_R, SYM_BLANK};
      KIND_CLEAR: sym_d = {4{SYM_BLANK}};
      default: sym_d = sym_q;
    endcase
  end

  // A command executes when the result queue has room for its transaction.
  assign cmd_fire  = cmd_head_i.valid && (rcnt_q != 2'd2);
  assign cmd_pop_o = cmd_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= {4{SYM_BLANK}};
    end else if (cmd_fire) begin
      sym_q <= sym_d;
    end
  end

  // Two-entry result queue toward the consumer.
  assign empty      = (rcnt_q == 2'd0);
  assign res_pop    = pop && !empty;
  assign out_data_o = res_q[rrd_q];

  always_comb begin
    rwr_d  = cmd_fire ? ~rwr_q : rwr_q;
    rrd_d  = res_pop ? ~rrd_q : rrd_q;
    rcnt_d = rcnt_q + 2'(cmd_fire) - 2'(res_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      rwr_q  <= rwr_d;
      rrd_q  <= rrd_d;
      rcnt_q <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      res_q[rwr_q] <= '{sym_pos0: sym_d[0], sym_pos1: sym_d[1], sym_pos2: sym_d[2],
                        sym_pos3: sym_d[3], ignored: ignored};
    end
  end

  `FDDF_ASSERT_NEXT(a_clear_blanks, cmd_fire && cmd.kind == KIND_CLEAR,
    sym_q == {4{SYM_BLANK}}, "clear did not blank all positions")
  `FDDF_ASSERT_NEXT(a_oor_keeps, cmd_fire && cmd.kind == KIND_DEC_OOR, $stable(sym_q),
    "ignored decimal changed the symbols")
  `FDDF_ASSERT_NEXT(a_res_lands, cmd_fire, !empty, "executed command left no result")

endmodule

// ----- sv/four_digit_display_formatter_top.sv -----
// Channel  | Direction | Handshake          | Payload
// input    | in        | push / full        | in_data_i  (func, number)
// result   | out       | empty / pop        | out_data_o (sym_pos0..3, ignored)
//
// Accepts one transaction per cycle while full is low; each yields exactly one result.
// A result appears once the command queue has held the transaction and the execute
// stage has written it to the result queue; a full result queue holds the command back.
// The held symbols reset to all blank; both queues reset empty.
// Two-entry queues sit before and after the execute stage, so a stalled consumer
// blocks input only once both queues are full.

module four_digit_display_formatter_top import fddf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  fddf_in_t  in_data_i,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output fddf_out_t out_data_o
);

  cmd_head_t cmd_head;
  logic      cmd_pop;

  // Front end: classify and queue commands.
  fddf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_data_i  (in_data_i),
    .full       (full),
    .cmd_pop_i  (cmd_pop),
    .cmd_head_o (cmd_head)
  );

  // Back end: update the held symbols and queue results.
  fddf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_head_i (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .out_data_o (out_data_o),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import fddf_pkg::*;

  // Largest value the hex command accepts.
  localparam int HEX_TOP = 65535;
  // Cycles without any transaction before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Cycles to keep watching for stray results once everything has arrived.
  localparam int DRAIN_CYCLES = 10;
  localparam int ITEMS_PER_PHASE = 212;
  localparam int MAX_REPORTS = 10;

  // One row of the directed stimulus table.
  typedef struct {
    fddf_in_t  cmd;
    bit        has_literal;
    fddf_out_t literal;
  } directed_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  logic      empty;
  logic      pop;
  fddf_in_t  in_data;
  fddf_out_t out_data;

  // Display symbols as the block should be holding them.
  logic [4:0] held_sym [4];
  fddf_out_t  expected_results [$];
  directed_row_t directed_rows [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  four_digit_display_formatter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_data_i  (in_data),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Builds a result transaction from its five fields.
  function automatic fddf_out_t symbol_row(logic [4:0] p0, logic [4:0] p1, logic [4:0] p2,
                                           logic [4:0] p3, logic ign);
    fddf_out_t r;
    r.sym_pos0 = p0;
    r.sym_pos1 = p1;
    r.sym_pos2 = p2;
    r.sym_pos3 = p3;
    r.ignored  = ign;
    return r;
  endfunction

  function automatic void add_directed(logic [1:0] f, logic signed [31:0] n, bit lit,
                                       fddf_out_t want);
    directed_row_t row;
    row.cmd.func    = f;
    row.cmd.number  = n;
    row.has_literal = lit;
    row.literal     = want;
    directed_rows.push_back(row);
  endfunction

  // Applies one command to the held symbols and returns what the block reports.
  function automatic fddf_out_t format_display(fddf_in_t cmd);
    fddf_out_t res;
    logic signed [31:0] value;
    logic [31:0] mag;
    logic neg;
    value = cmd.number;
    res.ignored = 1'b0;
    case (cmd.func)
      FUNC_DEC: begin
        if (value > DEC_MAX || value < DEC_MIN) begin
          res.ignored = 1'b1;
        end else begin
          neg = value < 0;
          mag = neg ? 32'(-value) : 32'(value);
          for (int i = 0; i < 4; i++) begin
            // Units digit always shows; above the top digit a dash for a negative value, then blanks.
            if (i != 0 && mag == 0 && neg) begin
              held_sym[i] = SYM_DASH;
              neg = 1'b0;
            end else if (i != 0 && mag == 0) begin
              held_sym[i] = SYM_BLANK;
            end else begin
              held_sym[i] = 5'(mag % 10);
            end
            mag = mag / 10;
          end
        end
      end
      FUNC_HEX: begin
        if (value < 0 || value > HEX_TOP) begin
          held_sym = '{SYM_BLANK, SYM_R, SYM_R, SYM_E};
        end else begin
          for (int i = 0; i < 4; i++) held_sym[i] = {1'b0, value[4*i +: 4]};
        end
      end
      FUNC_ERR: begin
        held_sym = '{SYM_BLANK, SYM_R, SYM_R, SYM_E};
      end
      default: begin
        held_sym = '{SYM_BLANK, SYM_BLANK, SYM_BLANK, SYM_BLANK};
      end
    endcase
    res.sym_pos0 = held_sym[0];
    res.sym_pos1 = held_sym[1];
    res.sym_pos2 = held_sym[2];
    res.sym_pos3 = held_sym[3];
    return res;
  endfunction

  // Random command, weighted toward in-range values with boundary and noise cases mixed in.
  function automatic fddf_in_t random_command();
    fddf_in_t c;
    int sel;
    sel = $urandom_range(99);
    c.number = $urandom;
    if (sel < 40) begin
      c.func = FUNC_DEC;
      if ($urandom_range(3) == 0) c.number = int'($urandom_range(20)) - 10;
      else c.number = int'($urandom_range(10998)) - 999;
    end else if (sel < 50) begin
      c.func = FUNC_DEC;
      case ($urandom_range(2))
        0: c.number = 10000 + int'($urandom_range(50));
        1: c.number = -1000 - int'($urandom_range(50));
        default: ;
      endcase
    end else if (sel < 70) begin
      c.func = FUNC_HEX;
      c.number = $urandom_range(HEX_TOP);
    end else if (sel < 78) begin
      c.func = FUNC_HEX;
      case ($urandom_range(2))
        0: c.number = HEX_TOP + 1 + int'($urandom_range(50));
        1: c.number = -1 - int'($urandom_range(50));
        default: ;
      endcase
    end else if (sel < 86) begin
      c.func = FUNC_ERR;
    end else if (sel < 94) begin
      c.func = FUNC_CLEAR;
    end else begin
      c.func = 2'($urandom_range(3));
    end
    return c;
  endfunction

  // Offers one transaction, after an optional idle gap, and records its expected result.
  task automatic send_command(fddf_in_t cmd, bit has_literal, fddf_out_t literal);
    fddf_out_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    in_data <= cmd;
    do @(posedge clk_i); while (full);
    predicted = format_display(cmd);
    expected_results.push_back(has_literal ? literal : predicted);
    @(negedge clk_i);
  endtask

  // Stimulus and end of run.
  initial begin
    rst_ni  = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    in_data = '0;
    held_sym = '{SYM_BLANK, SYM_BLANK, SYM_BLANK, SYM_BLANK};

    // Directed table: range limits, every command, dash placement, error patterns.
    add_directed(FUNC_DEC, 0, 1, symbol_row(0, SYM_BLANK, SYM_BLANK, SYM_BLANK, 0));
    add_directed(FUNC_DEC, 9999, 1, symbol_row(9, 9, 9, 9, 0));
    add_directed(FUNC_DEC, -999, 1, symbol_row(9, 9, 9, SYM_DASH, 0));
    add_directed(FUNC_DEC, 10000, 1, symbol_row(9, 9, 9, SYM_DASH, 1));
    add_directed(FUNC_DEC, -1000, 1, symbol_row(9, 9, 9, SYM_DASH, 1));
    add_directed(FUNC_DEC, 32'sh7fffffff, 1, symbol_row(9, 9, 9, SYM_DASH, 1));
    add_directed(FUNC_DEC, 32'sh80000000, 1, symbol_row(9, 9, 9, SYM_DASH, 1));
    add_directed(FUNC_HEX, HEX_TOP, 1, symbol_row(15, 15, 15, 15, 0));
    add_directed(FUNC_HEX, HEX_TOP + 1, 1, symbol_row(SYM_BLANK, SYM_R, SYM_R, SYM_E, 0));
    add_directed(FUNC_CLEAR, -1, 1,
                 symbol_row(SYM_BLANK, SYM_BLANK, SYM_BLANK, SYM_BLANK, 0));
    add_directed(FUNC_HEX, -1, 1, symbol_row(SYM_BLANK, SYM_R, SYM_R, SYM_E, 0));
    add_directed(FUNC_HEX, 0, 1, symbol_row(0, 0, 0, 0, 0));
    add_directed(FUNC_ERR, 0, 1, symbol_row(SYM_BLANK, SYM_R, SYM_R, SYM_E, 0));
    add_directed(FUNC_DEC, -1, 1, symbol_row(1, SYM_DASH, SYM_BLANK, SYM_BLANK, 0));
    add_directed(FUNC_CLEAR, 0, 1,
                 symbol_row(SYM_BLANK, SYM_BLANK, SYM_BLANK, SYM_BLANK, 0));
    add_directed(FUNC_HEX, 32'sh80000000, 1,
                 symbol_row(SYM_BLANK, SYM_R, SYM_R, SYM_E, 0));
    add_directed(FUNC_DEC, 7, 0, '0);
    add_directed(FUNC_DEC, -45, 0, '0);
    add_directed(FUNC_DEC, 120, 0, '0);
    add_directed(FUNC_DEC, 1000, 0, '0);
    add_directed(FUNC_DEC, -99, 0, '0);
    add_directed(FUNC_DEC, -10, 0, '0);
    add_directed(FUNC_HEX, 32'h1234, 0, '0);
    add_directed(FUNC_HEX, 32'hABCD, 0, '0);
    add_directed(FUNC_DEC, 99999, 0, '0);
    add_directed(FUNC_ERR, 32'sh7fffffff, 0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].has_literal,
                   directed_rows[i].literal);
    end

    // Random phases: free flow, sender gaps, receiver stalls, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 54; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 54; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_command(random_command(), 0, '0);
    end
    push <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[four_digit_display_formatter_top] OK");
    end else begin
      $display("[four_digit_display_formatter_top] ERROR");
    end
    $finish;
  end

  // Result side: random stalls on pop.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    fddf_out_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected result: pos0..3 %0d %0d %0d %0d ignored %0b",
                   out_data.sym_pos0, out_data.sym_pos1, out_data.sym_pos2,
                   out_data.sym_pos3, out_data.ignored);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data.sym_pos0 !== want.sym_pos0 || out_data.sym_pos1 !== want.sym_pos1 ||
            out_data.sym_pos2 !== want.sym_pos2 || out_data.sym_pos3 !== want.sym_pos3 ||
            out_data.ignored !== want.ignored) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch: expected %0d %0d %0d %0d ign %0b, got %0d %0d %0d %0d ign %0b",
                     want.sym_pos0, want.sym_pos1, want.sym_pos2, want.sym_pos3,
                     want.ignored, out_data.sym_pos0, out_data.sym_pos1,
                     out_data.sym_pos2, out_data.sym_pos3, out_data.ignored);
          end
        end
      end
    end
  end

  // Watchdog: give up when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("[four_digit_display_formatter_top] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/fddf_pkg.sv
sv/fddf_front.sv
sv/fddf_back.sv
sv/four_digit_display_formatter_top.sv
test/tb_top.sv
